[rtl/uart_command_frame_decoder_top_macros.svh]
// Assertion helpers for the frame decoder checker.
`ifndef UART_COMMAND_FRAME_DECODER_TOP_MACROS_SVH
`define UART_COMMAND_FRAME_DECODER_TOP_MACROS_SVH

// Check on every clock edge, reset included.
`define UCFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Check on every clock edge outside reset.
`define UCFD_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[rtl/ucfd_pkg.sv]
package ucfd_pkg;

  localparam int FRAME_KEEP = 7;

  localparam logic       FUNC_BYTE = 1'b0;
  localparam logic       FUNC_IDLE = 1'b1;

  localparam logic [7:0] HDR_FIRST       = 8'hAA;
  localparam logic [7:0] HDR_SECOND      = 8'h55;
  localparam logic [7:0] CMD_TOGGLE      = 8'h01;
  localparam logic [7:0] CMD_PARAM_FIRST = 8'h02;
  localparam logic [7:0] CMD_PARAM_LAST  = 8'h0A;
  localparam logic [7:0] CMD_SENSOR      = 8'h0C;
  localparam logic [7:0] CMD_VLIMIT      = 8'h0D;
  localparam logic [7:0] CMD_SAVE        = 8'h0E;

  localparam logic [4:0] COUNT_MAX = 5'd31;

  typedef logic [FRAME_KEEP-1:0][7:0] frame_t;

  typedef struct packed {
    logic        run;
    logic [7:0]  sensor;
    logic [15:0] upper;
    logic [15:0] lower;
  } ctrl_state_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  command;
    logic [3:0]  param_select;
    logic [31:0] param_value;
    logic        motor_run;
    logic        start_pulse;
    logic        stop_pulse;
    logic [7:0]  sensor_mode;
    logic [15:0] volt_upper;
    logic [15:0] volt_lower;
    logic        save_request;
  } result_t;

endpackage

[rtl/ucfd_rx_if.sv]
interface ucfd_rx_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

[rtl/ucfd_result_if.sv]
interface ucfd_result_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [7:0]  command;
  logic [3:0]  param_select;
  logic [31:0] param_value;
  logic        motor_run;
  logic        start_pulse;
  logic        stop_pulse;
  logic [7:0]  sensor_mode;
  logic [15:0] volt_upper;
  logic [15:0] volt_lower;
  logic        save_request;

  modport source (
    output valid, output status, output command, output param_select,
    output param_value, output motor_run, output start_pulse, output stop_pulse,
    output sensor_mode, output volt_upper, output volt_lower, output save_request,
    input ready
  );
  modport sink (
    input valid, input status, input command, input param_select,
    input param_value, input motor_run, input start_pulse, input stop_pulse,
    input sensor_mode, input volt_upper, input volt_lower, input save_request,
    output ready
  );
endinterface

[rtl/ucfd_frame_eval.sv]
module ucfd_frame_eval (
  input  ucfd_pkg::frame_t      frame,
  input  ucfd_pkg::ctrl_state_t cur,
  output ucfd_pkg::ctrl_state_t nxt,
  output ucfd_pkg::result_t     res
);
  import ucfd_pkg::*;

  localparam logic [7:0] EXP_ONE = 8'd127;
  localparam logic [7:0] EXP_SAT = 8'd135;
  localparam logic [7:0] EXP_TOP = 8'd134;
  localparam logic [7:0] EXP_SPECIAL = 8'hFF;

  // Truncate an IEEE single toward zero into 0..255, saturating; negatives and NaN give 0.
  function automatic logic [7:0] float_to_u8(input logic [31:0] bits);
    logic        sgn;
    logic [7:0]  expo;
    logic [22:0] mant;
    logic [23:0] sig;
    logic [7:0]  sh_wide;
    logic [7:0]  val;
    sgn     = bits[31];
    expo    = bits[30:23];
    mant    = bits[22:0];
    sig     = {1'b1, mant};
    sh_wide = EXP_TOP - expo;
    if (expo == EXP_SPECIAL && mant != '0) begin
      val = 8'd0;
    end else if (sgn) begin
      val = 8'd0;
    end else if (expo == EXP_SPECIAL) begin
      val = 8'hFF;
    end else if (expo < EXP_ONE) begin
      val = 8'd0;
    end else if (expo >= EXP_SAT) begin
      val = 8'hFF;
    end else begin
      val = sig[23:16] >> sh_wide[2:0];
    end
    return val;
  endfunction

  logic        hdr_ok;
  logic [7:0]  cmd;
  logic [31:0] data;
  logic [7:0]  sel_wide;

  assign hdr_ok   = (frame[0] == HDR_FIRST) && (frame[1] == HDR_SECOND);
  assign cmd      = frame[2];
  assign data     = {frame[6], frame[5], frame[4], frame[3]};
  assign sel_wide = cmd - CMD_TOGGLE;

  always_comb begin
    nxt = cur;
    res = '0;
    if (hdr_ok) begin
      res.status  = 1'b1;
      res.command = cmd;
      unique case (cmd) inside
        CMD_TOGGLE: begin
          nxt.run         = !cur.run;
          res.start_pulse = !cur.run;
          res.stop_pulse  = cur.run;
        end
        [CMD_PARAM_FIRST:CMD_PARAM_LAST]: begin
          res.param_select = sel_wide[3:0];
          res.param_value  = data;
        end
        CMD_SENSOR: nxt.sensor = float_to_u8(data);
        CMD_VLIMIT: begin
          nxt.upper = data[15:0];
          nxt.lower = data[31:16];
        end
        CMD_SAVE: res.save_request = 1'b1;
        default: ;
      endcase
    end
    res.motor_run   = nxt.run;
    res.sensor_mode = nxt.sensor;
    res.volt_upper  = nxt.upper;
    res.volt_lower  = nxt.lower;
  end

endmodule

[rtl/uart_command_frame_decoder_top.sv]
// A result word is registered when its line-idle word is taken: into out_reg, or into skid_reg if out_reg is stalled.
// Throughput: one rx word per cycle; a two-deep result buffer (output register plus
// skid register) keeps rx_ch ready until both are full.
// Reset (rst, synchronous): clears the frame buffer, byte count, run flag, sensor mode,
// voltage limits and both result valid flags.
module uart_command_frame_decoder_top #(
  parameter int RX_BUFFER_LEN = 16
) (
  input logic    clk,
  input logic    rst,
  ucfd_rx_if.sink       rx_ch,
  ucfd_result_if.source result_ch
);
  import ucfd_pkg::*;

  // Frame capture state: first bytes of the frame and a saturating byte count.
  frame_t      frame;
  logic [4:0]  byte_count;
  ctrl_state_t ctrl;
  ctrl_state_t ctrl_next;
  result_t     res_next;

  // Result buffer: out_reg drives the port, skid_reg catches a word that
  // arrives while out_reg is stalled.
  result_t out_reg;
  result_t skid_reg;
  logic    out_valid;
  logic    skid_valid;

  logic rx_take;
  logic idle_take;
  logic byte_take;
  logic res_pop;

  assign rx_ch.ready = !skid_valid;
  assign rx_take     = rx_ch.valid && rx_ch.ready;
  assign idle_take   = rx_take && (rx_ch.func == FUNC_IDLE);
  assign byte_take   = rx_take && (rx_ch.func == FUNC_BYTE);
  assign res_pop     = out_valid && result_ch.ready;

  // Judge the captured frame and work out the state it leaves behind.
  ucfd_frame_eval u_eval (
    .frame (frame),
    .cur   (ctrl),
    .nxt   (ctrl_next),
    .res   (res_next)
  );

  // Capture bytes; on line idle commit the command state and restart the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame      <= '0;
      byte_count <= '0;
      ctrl       <= '0;
    end else if (idle_take) begin
      frame      <= '0;
      byte_count <= '0;
      ctrl       <= ctrl_next;
    end else if (byte_take) begin
      if (int'(byte_count) < RX_BUFFER_LEN) begin
        // Keep only the head of the frame; later bytes just advance the count.
        if (int'(byte_count) < FRAME_KEEP) begin
          frame[byte_count[2:0]] <= rx_ch.rx_byte;
        end
        if (byte_count < COUNT_MAX) begin
          byte_count <= byte_count + 5'd1;
        end
      end
    end
  end

  // Result buffer valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // Input is held off here, so only a pop can happen: advance the skid word.
      if (res_pop) begin
        skid_valid <= 1'b0;
      end
    end else if (idle_take) begin
      if (out_valid && !res_pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (res_pop) begin
      out_valid <= 1'b0;
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (res_pop) begin
        out_reg <= skid_reg;
      end
    end else if (idle_take) begin
      if (out_valid && !res_pop) begin
        skid_reg <= res_next;
      end else begin
        out_reg <= res_next;
      end
    end
  end

  assign result_ch.valid        = out_valid;
  assign result_ch.status       = out_reg.status;
  assign result_ch.command      = out_reg.command;
  assign result_ch.param_select = out_reg.param_select;
  assign result_ch.param_value  = out_reg.param_value;
  assign result_ch.motor_run    = out_reg.motor_run;
  assign result_ch.start_pulse  = out_reg.start_pulse;
  assign result_ch.stop_pulse   = out_reg.stop_pulse;
  assign result_ch.sensor_mode  = out_reg.sensor_mode;
  assign result_ch.volt_upper   = out_reg.volt_upper;
  assign result_ch.volt_lower   = out_reg.volt_lower;
  assign result_ch.save_request = out_reg.save_request;

endmodule

[rtl/ucfd_checker.sv]
`include "uart_command_frame_decoder_top_macros.svh"

module ucfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        status,
  input logic [7:0]  command,
  input logic [3:0]  param_select,
  input logic [31:0] param_value,
  input logic        motor_run,
  input logic        start_pulse,
  input logic        stop_pulse,
  input logic        save_request
);

  // Reset empties the result buffer.
  `UCFD_ASSERT_ALWAYS(a_reset_empty, rst |=> !res_valid, "result valid after reset")

  // A stalled result word stays valid and holds its command, parameter value and status.
  `UCFD_ASSERT_RUN(a_stall_hold, res_valid && !res_ready |=> res_valid && $stable(command) && $stable(param_value) && $stable(status), "stalled result changed")

  // A dropped frame carries no command effects.
  `UCFD_ASSERT_RUN(a_bad_header_quiet, res_valid && !status |-> command == 8'd0 && param_select == 4'd0 && param_value == 32'd0 && !start_pulse && !stop_pulse && !save_request, "bad header with command effects")

  // A start pulse leaves the motor running, a stop pulse leaves it off.
  `UCFD_ASSERT_RUN(a_pulse_run, res_valid && (start_pulse || stop_pulse) |-> (start_pulse != stop_pulse) && (motor_run == start_pulse), "run flag disagrees with pulse")

endmodule

bind uart_command_frame_decoder_top ucfd_checker u_ucfd_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result_ch.valid),
  .res_ready    (result_ch.ready),
  .status       (result_ch.status),
  .command      (result_ch.command),
  .param_select (result_ch.param_select),
  .param_value  (result_ch.param_value),
  .motor_run    (result_ch.motor_run),
  .start_pulse  (result_ch.start_pulse),
  .stop_pulse   (result_ch.stop_pulse),
  .save_request (result_ch.save_request)
);
